// ===== rtl/quoted_printable_decoder_core_defines.svh =====
// Assertion macros for the checker file of the decoder.
`ifndef QUOTED_PRINTABLE_DECODER_CORE_DEFINES_SVH
`define QUOTED_PRINTABLE_DECODER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define QPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define QPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/qpd_pkg.sv =====
package qpd_pkg;

    // Characters with a meaning in quoted-printable text
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // A single input byte causes at most this many result bytes
    localparam int JOB_SLOTS = 3;

    typedef logic [1:0] slot_idx_t;

    // Work for the back end: up to three bytes caused by one request
    typedef struct packed {
        slot_idx_t                   cnt;    // number of results, 1 to 3
        logic [JOB_SLOTS-1:0][7:0]   bytes;  // results, slot 0 first
        logic                        empty;  // single empty end marker
        logic                        last;   // final byte of the message
    } job_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/qpd_front.sv =====
module qpd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic          in_final,
    output logic          in_ready,
    input  logic          q_ready,
    output logic          push,
    output qpd_pkg::job_t job
);
    import qpd_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_EQ   = 2'd1;
    localparam logic [1:0] PH_HELD = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic       hold_eq;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    // An equals sign that is not the final byte opens a new escape
    assign hold_eq  = (in_byte == CH_EQ) && !in_final;

    // Classify the byte against the pending escape
    always_comb
    begin
        job        = '0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_EQ:
            begin
                if (in_byte == CH_LF)
                begin
                    phase_next = PH_IDLE;
                end
                else if ((in_byte == CH_CR || is_hex(in_byte)) && !in_final)
                begin
                    phase_next = PH_HELD;
                    held_next  = in_byte;
                end
                else
                begin
                    job.bytes[0] = CH_EQ;
                    if (hold_eq)
                    begin
                        job.cnt    = 2'd1;
                        phase_next = PH_EQ;
                    end
                    else
                    begin
                        job.bytes[1] = in_byte;
                        job.cnt      = 2'd2;
                    end
                end
            end
            PH_HELD:
            begin
                if (held_reg == CH_CR && in_byte == CH_LF)
                begin
                    phase_next = PH_IDLE;
                end
                else if (held_reg != CH_CR && is_hex(held_reg) && is_hex(in_byte))
                begin
                    job.bytes[0] = {hex_val(held_reg), hex_val(in_byte)};
                    job.cnt      = 2'd1;
                end
                else
                begin
                    job.bytes[0] = CH_EQ;
                    job.bytes[1] = held_reg;
                    if (hold_eq)
                    begin
                        job.cnt    = 2'd2;
                        phase_next = PH_EQ;
                    end
                    else
                    begin
                        job.bytes[2] = in_byte;
                        job.cnt      = 2'd3;
                    end
                end
            end
            default:
            begin
                if (hold_eq)
                begin
                    phase_next = PH_EQ;
                end
                else
                begin
                    job.bytes[0] = in_byte;
                    job.cnt      = 2'd1;
                end
            end
        endcase

        // Close the message: drop any escape, mark an empty run
        if (in_final)
        begin
            phase_next = PH_IDLE;
            job.last   = 1'b1;
            if (job.cnt == 2'd0)
            begin
                job.cnt   = 2'd1;
                job.empty = 1'b1;
            end
        end
    end

    assign push = accept && (job.cnt != 2'd0);

    // Advance escape state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== rtl/qpd_queue.sv =====
module qpd_queue #(
    parameter int DEPTH = 4    // 2 or more
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qpd_pkg::job_t push_job,
    output logic          in_ready,
    input  logic          pop,
    output logic          out_valid,
    output qpd_pkg::job_t head_job
);
    import qpd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign head_job  = slots_reg[rd_ptr_reg];

    // Wrap pointers and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job at the write pointer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/qpd_back.sv =====
module qpd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  qpd_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_flag,
    output logic          out_last
);
    import qpd_pkg::*;

    slot_idx_t  idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       flag_reg, flag_next;
    logic       last_reg, last_next;
    logic       load;
    logic       take;
    logic       final_slot;

    // Refill the output register whenever it is empty or being drained
    assign load       = !valid_reg || out_ready;
    assign take       = load && q_valid;
    assign final_slot = (idx_reg == head_job.cnt - 2'd1);
    assign pop        = take && final_slot;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = load ? q_valid : valid_reg;
        byte_next  = byte_reg;
        flag_next  = flag_reg;
        last_next  = last_reg;
        if (take)
        begin
            byte_next = head_job.bytes[idx_reg];
            flag_next = !head_job.empty;
            last_next = head_job.last && final_slot;
            idx_next  = final_slot ? '0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        flag_reg <= flag_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_flag  = flag_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/quoted_printable_decoder_core.sv =====
// Channel  | Fields                                | Handshake
// s_axis   | tdata: in_byte; tlast: final_byte      | tvalid/tready
// m_axis   | tdata: out_byte; tuser: byte_valid;    | tvalid/tready
//          | tlast: run_last                        |
//
// One request is taken per cycle while the job queue has room; the front end
// decodes it in the same cycle. The back end hands out one result per cycle
// from its output register when m_axis_tready is high; a request that expands
// to two or three bytes sends them in turn. A first result passes the queue
// and then the output register. The queue holds QUEUE_DEPTH jobs before
// s_axis_tready drops. rst_n clears escape state, queue and output valid.
module quoted_printable_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] byte_valid
    output logic       m_axis_tlast
);
    import qpd_pkg::*;

    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic q_ready;
    logic q_valid;

    // Classify each request against the escape state
    qpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_final (s_axis_tlast),
        .in_ready (s_axis_tready),
        .q_ready  (q_ready),
        .push     (push),
        .job      (front_job)
    );

    // Decouple front and back
    qpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (front_job),
        .in_ready  (q_ready),
        .pop       (pop),
        .out_valid (q_valid),
        .head_job  (head_job)
    );

    // Serialize jobs into single result bytes
    qpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_flag  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== rtl/qpd_checker.sv =====
`include "quoted_printable_decoder_core_defines.svh"

module qpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    logic marker_ok;

    // An empty marker closes the message and carries a zero byte
    assign marker_ok = m_axis_tlast && (m_axis_tdata == 8'h00);

    // Keep a stalled result on the bus
    `QPD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

    // Hold a stalled result's payload steady
    `QPD_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}), "result changed")

    // An empty marker only closes a message and carries a zero byte
    `QPD_ASSERT(a_marker_last, m_axis_tvalid && !m_axis_tuser |-> marker_ok, "empty marker malformed")

    // No result shows while reset is held
    `QPD_ASSERT_ALWAYS(a_reset_quiet, !rst_n && $past(!rst_n) |-> !m_axis_tvalid, "valid in reset")

endmodule

bind quoted_printable_decoder_core qpd_checker u_qpd_checker (.*);
